### hw/rtl/case_insensitive_kmp_line_counter_macros.svh
// Assertion macros shared by the line counter and its walker.
// Both macros expect aclk and aresetn to exist in the module that uses them.
`ifndef CASE_INSENSITIVE_KMP_LINE_COUNTER_MACROS_SVH
`define CASE_INSENSITIVE_KMP_LINE_COUNTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define CIKMP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cikmp: same-cycle check failed");

// Next-cycle implication.
`define CIKMP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cikmp: next-cycle check failed");

`else

`define CIKMP_ASSERT_IMP(label, ante, cons)

`define CIKMP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### hw/rtl/cikmp_pkg.sv
`default_nettype none

package cikmp_pkg;

    localparam int MAX_PATTERN = 128;
    localparam int PTR_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

    localparam int FUNC_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int LINE_W  = 24;
    localparam int COUNT_W = 16;
    localparam int TOTAL_W = 32;

    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_NEW_SEARCH = 3'd0,
        FUNC_PATTERN    = 3'd1,
        FUNC_TEXT       = 3'd2,
        FUNC_END_LINE   = 3'd3,
        FUNC_NEW_FILE   = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EOL
    } ctl_state_t;

    typedef enum logic [1:0] {
        W_IDLE,
        W_SEED,
        W_TEST
    } walk_state_t;

    // Request from the controller to the walker.
    typedef struct packed {
        logic              start;
        logic              build;
        logic [BYTE_W-1:0] c;
        logic [LEN_W-1:0]  k;
        logic [LEN_W-1:0]  len;
    } walk_req_t;

    // Completion from the walker.
    typedef struct packed {
        logic             done;
        logic             build;
        logic [LEN_W-1:0] k;
    } walk_rsp_t;

    // Fold ASCII upper case letters to lower case; all other bytes pass.
    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/case_insensitive_kmp_line_counter.sv
`default_nettype none
// Channel   Direction  Ports                                      Item
// s_        in         s_valid s_ready s_func s_byte_value         one command or byte
// m_        out        m_valid m_ready m_line_number m_line_count  one line report
//                      m_running_total m_found
//
// New search, new file, unused codes, a dropped pattern byte and a text byte under an
// empty pattern are taken in the idle state alone; any other pattern or text byte starts
// a walk in which the single compare unit follows failure links, one pattern byte and one
// link read per cycle; the first pattern byte seeds the failure store instead.
// Reset: synchronous, active low; the pattern empties, the line number returns to 1 and
// all counters clear. A held report does not block input; only an end of line waits.

`include "case_insensitive_kmp_line_counter_macros.svh"

module case_insensitive_kmp_line_counter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [cikmp_pkg::FUNC_W-1:0]    s_func,
    input  logic [cikmp_pkg::BYTE_W-1:0]    s_byte_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cikmp_pkg::LINE_W-1:0]    m_line_number,
    output logic [cikmp_pkg::COUNT_W-1:0]   m_line_count,
    output logic [cikmp_pkg::TOTAL_W-1:0]   m_running_total,
    output logic                            m_found
);
    import cikmp_pkg::*;

    // Controller state. A nonzero match position is always below the pattern
    // length, so it fits the store's address width.
    ctl_state_t          state_reg, state_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [PTR_W-1:0]    build_pos_reg, build_pos_next;
    logic [PTR_W-1:0]    match_pos_reg, match_pos_next;
    logic [PTR_W-1:0]    tail_fail_reg, tail_fail_next;
    logic [COUNT_W-1:0]  line_matches_reg, line_matches_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [LINE_W-1:0]   cur_line_reg, cur_line_next;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    logic [LINE_W-1:0]   m_line_number_reg, m_line_number_next;
    logic [COUNT_W-1:0]  m_line_count_reg, m_line_count_next;
    logic [TOTAL_W-1:0]  m_running_total_reg, m_running_total_next;
    logic                m_found_reg, m_found_next;

    walk_req_t           walk_req;
    walk_rsp_t           walk_rsp;

    logic [TOTAL_W:0]    total_sum;
    logic [TOTAL_W-1:0]  total_sat;
    logic                eol_load;

    cikmp_walker u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (walk_req),
        .rsp     (walk_rsp)
    );

    // Input is taken whenever no walk or end of line is pending.
    assign s_ready = (state_reg == ST_IDLE);

    // The running total saturates instead of wrapping.
    assign total_sum = {1'b0, total_reg} + (TOTAL_W + 1)'(line_matches_reg);
    assign total_sat = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

    // A pending end of line reports once the output register is free or being emptied.
    assign eol_load = (state_reg == ST_EOL) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next           = state_reg;
        len_next             = len_reg;
        build_pos_next       = build_pos_reg;
        match_pos_next       = match_pos_reg;
        tail_fail_next       = tail_fail_reg;
        line_matches_next    = line_matches_reg;
        total_next           = total_reg;
        cur_line_next        = cur_line_reg;
        m_valid_next         = m_valid_reg && !m_ready;
        m_line_number_next   = m_line_number_reg;
        m_line_count_next    = m_line_count_reg;
        m_running_total_next = m_running_total_reg;
        m_found_next         = m_found_reg;

        walk_req       = '0;
        walk_req.c     = fold_byte(s_byte_value);
        walk_req.len   = len_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (func_t'(s_func))
                        FUNC_NEW_SEARCH: begin
                            len_next          = '0;
                            build_pos_next    = '0;
                            match_pos_next    = '0;
                            line_matches_next = '0;
                            total_next        = '0;
                            cur_line_next     = LINE_W'(1);
                        end
                        FUNC_PATTERN: begin
                            // Bytes past the store's capacity are dropped.
                            if (len_reg < LEN_MAX) begin
                                walk_req.start = 1'b1;
                                walk_req.build = 1'b1;
                                walk_req.k     = LEN_W'(build_pos_reg);
                                state_next     = ST_WALK;
                            end
                        end
                        FUNC_TEXT: begin
                            // An empty pattern never matches.
                            if (len_reg != '0) begin
                                walk_req.start = 1'b1;
                                walk_req.k     = LEN_W'(match_pos_reg);
                                state_next     = ST_WALK;
                            end
                        end
                        FUNC_END_LINE: begin
                            state_next = ST_EOL;
                        end
                        FUNC_NEW_FILE: begin
                            match_pos_next    = '0;
                            line_matches_next = '0;
                            total_next        = '0;
                            cur_line_next     = LINE_W'(1);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (walk_rsp.done) begin
                    if (walk_rsp.build) begin
                        // The new failure link is also the link of the last
                        // pattern byte, which a full match falls back to.
                        build_pos_next = walk_rsp.k[PTR_W-1:0];
                        tail_fail_next = walk_rsp.k[PTR_W-1:0];
                        len_next       = len_reg + LEN_ONE;
                    end else if (walk_rsp.k >= len_reg) begin
                        // Full match: count it and keep the overlap.
                        if (line_matches_reg != '1) begin
                            line_matches_next = line_matches_reg + COUNT_W'(1);
                        end
                        match_pos_next = tail_fail_reg;
                    end else begin
                        match_pos_next = walk_rsp.k[PTR_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_EOL: begin
                // Report once the output register is free or being emptied.
                if (eol_load) begin
                    total_next           = total_sat;
                    m_valid_next         = 1'b1;
                    m_line_number_next   = cur_line_reg;
                    m_line_count_next    = line_matches_reg;
                    m_running_total_next = total_sat;
                    m_found_next         = (line_matches_reg != '0);
                    if (cur_line_reg != '1) begin
                        cur_line_next = cur_line_reg + LINE_W'(1);
                    end
                    line_matches_next    = '0;
                    match_pos_next       = '0;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            len_reg          <= '0;
            build_pos_reg    <= '0;
            match_pos_reg    <= '0;
            line_matches_reg <= '0;
            total_reg        <= '0;
            cur_line_reg     <= LINE_W'(1);
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            len_reg          <= len_next;
            build_pos_reg    <= build_pos_next;
            match_pos_reg    <= match_pos_next;
            line_matches_reg <= line_matches_next;
            total_reg        <= total_next;
            cur_line_reg     <= cur_line_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tail_fail_reg       <= tail_fail_next;
        m_line_number_reg   <= m_line_number_next;
        m_line_count_reg    <= m_line_count_next;
        m_running_total_reg <= m_running_total_next;
        m_found_reg         <= m_found_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_line_number   = m_line_number_reg;
    assign m_line_count    = m_line_count_reg;
    assign m_running_total = m_running_total_reg;
    assign m_found         = m_found_reg;

    `CIKMP_ASSERT_IMP(a_match_below_len, match_pos_reg != '0, LEN_W'(match_pos_reg) < len_reg)
    `CIKMP_ASSERT_IMP(a_done_only_in_walk, walk_rsp.done, state_reg == ST_WALK)
    `CIKMP_ASSERT_IMP(a_found_follows_count, m_valid_reg, m_found_reg == (m_line_count_reg != '0))
    `CIKMP_ASSERT_NEXT(a_eol_loads_output, eol_load, m_valid_reg && (state_reg == ST_IDLE))

endmodule

`default_nettype wire

### hw/rtl/cikmp_walker.sv
`default_nettype none

`include "case_insensitive_kmp_line_counter_macros.svh"

module cikmp_walker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cikmp_pkg::walk_req_t  req,
    output cikmp_pkg::walk_rsp_t  rsp
);
    import cikmp_pkg::*;

    logic [BYTE_W-1:0] pattern_mem [MAX_PATTERN];
    logic [PTR_W-1:0]  failure_mem [MAX_PATTERN];

    walk_state_t       state_reg, state_next;
    logic [LEN_W-1:0]  k_reg, k_next;
    logic [BYTE_W-1:0] c_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              build_reg;

    logic [BYTE_W-1:0] pat_q_reg;
    logic [PTR_W-1:0]  fail_q_reg;

    logic              pat_we;
    logic              fail_we;
    logic [PTR_W-1:0]  fail_wa;
    logic [PTR_W-1:0]  fail_wd;
    logic [LEN_W-1:0]  k_dec;

    // Pattern at the next position, failure at one less; both reads are registered.
    assign k_dec = k_next - LEN_ONE;

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        rsp        = '0;
        pat_we     = 1'b0;
        fail_we    = 1'b0;
        fail_wa    = len_reg[PTR_W-1:0];
        fail_wd    = '0;
        case (state_reg)
            W_IDLE: begin
                if (req.start) begin
                    pat_we = req.build;
                    if (req.build && req.len == '0) begin
                        k_next     = '0;
                        state_next = W_SEED;
                    end else begin
                        k_next     = req.k;
                        state_next = W_TEST;
                    end
                end
            end
            W_SEED: begin
                fail_we    = 1'b1;
                fail_wa    = '0;
                fail_wd    = '0;
                rsp.done   = 1'b1;
                rsp.build  = build_reg;
                rsp.k      = '0;
                state_next = W_IDLE;
            end
            W_TEST: begin
                if (k_reg != '0 && c_reg != pat_q_reg) begin
                    k_next = LEN_W'(fail_q_reg);
                end else begin
                    if (c_reg == pat_q_reg) begin
                        k_next = k_reg + LEN_ONE;
                    end
                    rsp.done   = 1'b1;
                    rsp.build  = build_reg;
                    rsp.k      = k_next;
                    fail_we    = build_reg;
                    fail_wd    = k_next[PTR_W-1:0];
                    state_next = W_IDLE;
                end
            end
            default: begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= W_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg <= k_next;
        if (state_reg == W_IDLE && req.start) begin
            c_reg     <= req.c;
            len_reg   <= req.len;
            build_reg <= req.build;
        end
    end

    always_ff @(posedge aclk) begin
        if (pat_we) begin
            pattern_mem[req.len[PTR_W-1:0]] <= req.c;
        end
        pat_q_reg <= pattern_mem[k_next[PTR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (fail_we) begin
            failure_mem[fail_wa] <= fail_wd;
        end
        fail_q_reg <= failure_mem[k_dec[PTR_W-1:0]];
    end

    `CIKMP_ASSERT_IMP(a_walk_below_len, state_reg == W_TEST, k_reg < len_reg)
    `CIKMP_ASSERT_IMP(a_start_when_idle, req.start, state_reg == W_IDLE)
    `CIKMP_ASSERT_IMP(a_done_within_len, rsp.done, rsp.k <= len_reg)

endmodule

`default_nettype wire
